// ===== design/etc_pkg.sv =====
// Shared types and constants of the elimination tree and column count block.
package etc_pkg;

  localparam int MAX_N_DEFAULT = 64;

  localparam int SIZE_W      = 7;
  localparam int ROW_W       = 6;
  localparam int PARENT_W    = 7;
  localparam int COUNT_W     = 6;
  localparam int START_W     = 11;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  localparam logic [SIZE_W-1:0] MATRIX_SIZE_RESET = 7'd64;

  // Register index, taken from paddr[2].
  localparam logic REG_MATRIX_SIZE = 1'b0;

  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  typedef enum logic [1:0] {
    MODE_ENTRY   = 2'd0,
    MODE_CLOSE   = 2'd1,
    MODE_QUERY   = 2'd2,
    MODE_RESTART = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t            mode;
    logic [ROW_W-1:0] row_index;
  } cmd_t;

  typedef struct packed {
    logic signed [PARENT_W-1:0] parent_node;
    logic [COUNT_W-1:0]         entry_count;
    logic [START_W-1:0]         column_start;
    logic                       status;
  } result_t;

endpackage

// ===== design/etc_node_ram.sv =====
// Single-port-write, single-port-read node memory with registered read data.
module etc_node_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 19
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/etc_cfg.sv =====
// APB register holding the matrix size.
module etc_cfg
  import etc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output logic [SIZE_W-1:0]  matrix_size
);

  logic wr_size;

  assign pready  = 1'b1;
  assign wr_size = psel && penable && pwrite && (paddr[2] == REG_MATRIX_SIZE);

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size <= MATRIX_SIZE_RESET;
    end else if (wr_size) begin
      matrix_size <= pwdata[SIZE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_MATRIX_SIZE) begin
      prdata[SIZE_W-1:0] = matrix_size;
    end
  end

endmodule

// ===== design/etc_seq.sv =====
// Sequencer that walks the elimination tree and sums column counts over the node memory.
module etc_seq
  import etc_pkg::*;
#(
  parameter int MAX_N = MAX_N_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [SIZE_W-1:0] matrix_size,
  input  logic              start,
  input  cmd_t              cmd,
  output logic              busy,
  output logic              done,
  output result_t           result
);

  localparam int NW = $clog2(MAX_N);
  localparam int CW = $clog2(MAX_N + 1);
  localparam int DW = 1 + 3 * NW;

  typedef enum logic [1:0] {S_IDLE, S_OPEN, S_WALK, S_SUM} state_t;

  state_t                state;
  logic [CW-1:0]         cur;
  logic [NW-1:0]         open_idx;
  logic [NW-1:0]         node;
  logic [NW-1:0]         last;
  logic [START_W-1:0]    acc;

  logic                  we;
  logic [NW-1:0]         waddr;
  logic [DW-1:0]         wdata;
  logic [NW-1:0]         raddr;
  logic [DW-1:0]         rdata;

  logic [CW-1:0]         n_eff;
  logic [CW-1:0]         cur_inc;
  logic [NW-1:0]         k;
  logic [NW+ROW_W-1:0]   row_ext;
  logic [NW-1:0]         row_n;
  logic                  rd_root;
  logic [NW-1:0]         rd_parent;
  logic [NW-1:0]         rd_mark;
  logic [NW-1:0]         rd_count;
  logic [NW-1:0]         walk_next;
  logic                  cur_lt_n;
  logic                  row_lt_cur;
  logic                  row_lt_n;
  logic                  next_lt_cur;
  logic                  inc_lt_max;
  logic [NW+PARENT_W-1:0] parent_wide;
  logic [NW+COUNT_W-1:0]  count_wide;
  logic [NW+START_W-1:0]  acc_wide;
  logic [START_W-1:0]     acc_next;
  result_t                sum_result;
  result_t                reject_result;

  etc_node_ram #(
    .DEPTH (MAX_N),
    .AW    (NW),
    .DW    (DW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign busy = (state != S_IDLE);

  always_comb begin
    n_eff     = (int'(matrix_size) > MAX_N) ? CW'(MAX_N) : CW'(matrix_size);
    cur_inc   = cur + 1'b1;
    k         = cur[NW-1:0];
    row_ext   = {{NW{1'b0}}, cmd.row_index};
    row_n     = row_ext[NW-1:0];

    rd_root   = rdata[DW-1];
    rd_parent = rdata[3*NW-1:2*NW];
    rd_mark   = rdata[2*NW-1:NW];
    rd_count  = rdata[NW-1:0];
    walk_next = rd_root ? k : rd_parent;

    cur_lt_n    = cur < n_eff;
    row_lt_cur  = {{CW{1'b0}}, cmd.row_index} < {{ROW_W{1'b0}}, cur};
    row_lt_n    = {{CW{1'b0}}, cmd.row_index} < {{ROW_W{1'b0}}, n_eff};
    next_lt_cur = {{CW{1'b0}}, walk_next} < {{NW{1'b0}}, cur};
    inc_lt_max  = cur_inc < CW'(MAX_N);

    parent_wide = {{PARENT_W{1'b0}}, rd_parent};
    count_wide  = {{COUNT_W{1'b0}}, rd_count};
    acc_wide    = {{NW{1'b0}}, acc} + {{START_W{1'b0}}, rd_count};
    acc_next    = acc_wide[START_W-1:0];

    sum_result.parent_node  = rd_root ? '1 : parent_wide[PARENT_W-1:0];
    sum_result.entry_count  = count_wide[COUNT_W-1:0];
    sum_result.column_start = acc;
    sum_result.status       = STATUS_OK;

    reject_result.parent_node  = '0;
    reject_result.entry_count  = '0;
    reject_result.column_start = '0;
    reject_result.status       = STATUS_REJECT;

    // Memory port: the read address always points at the node the next cycle inspects.
    case (state)
      S_IDLE:  raddr = (cmd.mode == MODE_QUERY) ? '0 : row_n;
      S_WALK:  raddr = walk_next;
      S_SUM:   raddr = node + 1'b1;
      default: raddr = node;
    endcase

    we    = 1'b0;
    waddr = node;
    wdata = {1'b0, walk_next, k, rd_count + 1'b1};
    case (state)
      S_OPEN: begin
        we    = 1'b1;
        waddr = open_idx;
        wdata = {1'b1, {NW{1'b0}}, open_idx, {NW{1'b0}}};
      end
      S_WALK: begin
        we = (rd_mark != k);
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_OPEN;
      cur      <= '0;
      open_idx <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            case (cmd.mode)
              MODE_ENTRY: begin
                if (cur_lt_n && row_lt_cur) begin
                  node  <= row_n;
                  state <= S_WALK;
                end
              end
              MODE_CLOSE: begin
                if (cur_lt_n) begin
                  cur <= cur_inc;
                  if (inc_lt_max) begin
                    open_idx <= cur_inc[NW-1:0];
                    state    <= S_OPEN;
                  end
                end
              end
              MODE_QUERY: begin
                if (cur_lt_n || !row_lt_n) begin
                  done   <= 1'b1;
                  result <= reject_result;
                end else begin
                  node  <= '0;
                  last  <= row_n;
                  acc   <= '0;
                  state <= S_SUM;
                end
              end
              MODE_RESTART: begin
                cur      <= '0;
                open_idx <= '0;
                state    <= S_OPEN;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_OPEN: begin
          state <= S_IDLE;
        end
        S_WALK: begin
          if (rd_mark == k || !next_lt_cur) begin
            state <= S_IDLE;
          end else begin
            node <= walk_next;
          end
        end
        S_SUM: begin
          if (node == last) begin
            done   <= 1'b1;
            result <= sum_result;
            state  <= S_IDLE;
          end else begin
            acc  <= acc_next;
            node <= node + 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/elimination_tree_column_counts.sv =====
// Top level of the symbolic elimination tree and column count analysis block.
//
// This block builds the elimination tree and the per-column nonzero counts of L for a
// sparse symmetric matrix whose columns are fed in order. A transaction is taken when
// start is high and busy is low; cmd.mode selects a row entry of the current column,
// a column close, a node query or a matrix restart. Only queries produce a result: it
// appears on result for exactly one cycle with done high, and the receiver cannot
// stall it, so it must be captured in that cycle. Timing is set by the single node
// memory port, which is read once per cycle. A row entry that starts a walk keeps
// busy high while it visits nodes on its way toward the root, updating each node
// not yet marked for the current column, and stops at the root or at a node already
// marked. An entry or a close that the block ignores leaves busy low, and so does the
// close of column MAX_N - 1, since there is no further node to open. Any other close,
// and a restart, keeps busy high while the newly opened node is initialized. A query
// for node r reads nodes 0 through r in turn, summing the counts of the nodes before
// r to form the column start; busy stays high while it does so, and done goes high
// in the same cycle that busy falls. A rejected query (columns still open, or node
// outside the matrix) leaves busy low and answers in the cycle after it is taken,
// with status set. After reset the block keeps busy high while it initializes node
// zero. The matrix size is written through the APB port at byte address 0 and should
// only be changed while the block is idle; sizes above MAX_N behave as MAX_N.
module elimination_tree_column_counts
  import etc_pkg::*;
#(
  parameter int MAX_N = MAX_N_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  logic               start,
  input  cmd_t               cmd,
  output logic               busy,
  output logic               done,
  output result_t            result
);

  logic [SIZE_W-1:0] matrix_size;

  // Configuration register file.
  etc_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .matrix_size (matrix_size)
  );

  // Sequencer with the node memory: tree walks, node initialization and prefix sums.
  etc_seq #(
    .MAX_N (MAX_N)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .matrix_size (matrix_size),
    .start       (start),
    .cmd         (cmd),
    .busy        (busy),
    .done        (done),
    .result      (result)
  );

endmodule
